[src/oversampled_uart_with_fifos_defines.svh]
// Assertion macros for the oversampled UART block.
// Included by the top level; needs nothing else.
`ifndef OVERSAMPLED_UART_WITH_FIFOS_DEFINES_SVH
`define OVERSAMPLED_UART_WITH_FIFOS_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define OUF_CHECK(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition at the next edge.
`define OUF_CHECK_NEXT(name, clk, rst_n, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[src/ouf_pkg.sv]
// Shared types and constants for the oversampled UART block.
// No dependencies; used by every module of the block.
package ouf_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_OVERSAMPLE = 2'd0,
        REG_ENABLE     = 2'd1,
        REG_SPARE0     = 2'd2,
        REG_SPARE1     = 2'd3
    } reg_index_t;

    localparam logic [3:0] OVERSAMPLE_RESET = 4'd4;
    localparam logic       ENABLE_RESET     = 1'b1;
    localparam logic [3:0] BITS_PER_WORD    = 4'd8;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] tx_byte;
        logic       rx_line;
    } req_t;

    typedef struct packed {
        logic       tx_line;
        logic       tx_accepted;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_space;
        logic       rx_nonempty;
    } rsp_t;

    typedef struct packed {
        logic       tick;
        logic       push;
        logic       pop;
        logic [7:0] tx_byte;
        logic       rx_line;
    } op_t;

    typedef struct packed {
        logic [3:0] period;
        logic       enable;
    } cfg_t;

    typedef struct packed {
        logic line;
        logic accepted;
        logic space;
    } tx_stat_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       nonempty;
    } rx_stat_t;

endpackage

[src/oversampled_uart_with_fifos.sv]
// Oversampled 8N1 UART with transmit and receive byte FIFOs.
// Request channel (req_valid/req_ready/req) carries one command word: a tick
// with the sampled receive line, a push of a transmit byte, or a pop of a
// received byte. Every command word yields exactly one status word on the
// response channel (rsp_valid/rsp_ready/rsp) with the transmit line level,
// push and pop outcomes, the popped byte and both FIFO flags.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the ticks per
// bit (index 0) and the tick enable (index 1); it is always ready.
// An accepted word waits in the queue, and its status word is registered.
// Throughput: one word per cycle while rsp_ready is high; each word updates all
// state at once, with every FIFO read served from a prefetched head register.
// A two-word queue separates the request side from the back end; when the
// receiver stalls rsp_ready, the response register holds, the queue fills and
// req_ready drops after two more words.
// Reset: both FIFOs empty, both bit machines idle, transmit line high,
// ticks per bit 4, ticks enabled.
// Depends on ouf_pkg, ouf_front, ouf_tx, ouf_rx and the defines header.
`include "oversampled_uart_with_fifos_defines.svh"

module oversampled_uart_with_fifos
    import ouf_pkg::*;
#(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    logic     op_valid;
    op_t      op;
    logic     fire;
    cfg_t     cfg;
    logic [3:0] oversample_reg, oversample_next;
    logic     enable_reg, enable_next;
    tx_stat_t tx_stat;
    rx_stat_t rx_stat;
    logic     rsp_valid_reg, rsp_valid_next;
    rsp_t     rsp_reg, rsp_next;

    assign cfg_ready = 1'b1;
    assign fire      = op_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        oversample_next = oversample_reg;
        enable_next     = enable_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_OVERSAMPLE: oversample_next = cfg_data;
                REG_ENABLE:     enable_next     = cfg_data[0];
                default:        enable_next     = enable_reg;
            endcase
        end
        cfg.period = (oversample_reg == 4'd0) ? 4'd1 : oversample_reg;
        cfg.enable = enable_reg;
    end

    ouf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .take      (fire),
        .op_valid  (op_valid),
        .op        (op)
    );

    ouf_tx #(.DEPTH(TX_DEPTH)) u_tx (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .op    (op),
        .cfg   (cfg),
        .stat  (tx_stat)
    );

    ouf_rx #(.DEPTH(RX_DEPTH)) u_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .op    (op),
        .cfg   (cfg),
        .stat  (rx_stat)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (fire)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.tx_line     = tx_stat.line;
            rsp_next.tx_accepted = tx_stat.accepted;
            rsp_next.rx_valid    = rx_stat.valid;
            rsp_next.rx_byte     = rx_stat.data;
            rsp_next.tx_space    = tx_stat.space;
            rsp_next.rx_nonempty = rx_stat.nonempty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oversample_reg <= OVERSAMPLE_RESET;
            enable_reg     <= ENABLE_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            oversample_reg <= oversample_next;
            enable_reg     <= enable_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    `OUF_CHECK(a_no_overwrite, clk, rst_n, !(fire && rsp_valid_reg && !rsp_ready), "status word overwritten while stalled")
    `OUF_CHECK_NEXT(a_fire_gives_rsp, clk, rst_n, fire, rsp_valid_reg, "command word lost")
    `OUF_CHECK(a_one_kind, clk, rst_n, !(rsp_valid_reg && rsp_reg.tx_accepted && rsp_reg.rx_valid), "push and pop reported together")

endmodule

[src/ouf_front.sv]
// Front end: two-word input queue and command decode.
// Depends on ouf_pkg.
module ouf_front
    import ouf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    input  logic take,
    output logic op_valid,
    output op_t  op
);

    req_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       put;
    logic       get;
    req_t       head;

    assign req_ready = (cnt_reg != 2'd2);
    assign op_valid  = (cnt_reg != 2'd0);
    assign put       = req_valid && req_ready;
    assign get       = take && op_valid;
    assign head      = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = put ? ~wp_reg : wp_reg;
        rp_next  = get ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, put} - {1'b0, get};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            q_reg[wp_reg] <= req;
        end
    end

    // classify the head word
    always_comb
    begin
        op         = '0;
        op.tx_byte = head.tx_byte;
        op.rx_line = head.rx_line;
        case (cmd_t'(head.cmd))
            CMD_TICK: op.tick = 1'b1;
            CMD_PUSH: op.push = 1'b1;
            CMD_POP:  op.pop  = 1'b1;
            default:  op.tick = 1'b0;
        endcase
    end

endmodule

[src/ouf_tx.sv]
// Transmit side: byte FIFO with prefetched head and the 8N1 bit machine.
// Depends on ouf_pkg.
module ouf_tx
    import ouf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  op_t      op,
    input  cfg_t     cfg,
    output tx_stat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    head_reg;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] fp_reg, fp_next;
    logic [FW-1:0] fill_reg, fill_next;
    phase_t        phase_reg, phase_next;
    logic [3:0]    bits_reg, bits_next;
    logic [7:0]    shift_reg, shift_next;
    logic [3:0]    div_reg, div_next;
    logic          line_reg, line_next;
    logic          push_ok;
    logic [3:0]    div_sum;
    logic [3:0]    bits_sum;
    logic [FW-1:0] fill_dec;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign push_ok  = fire && op.push && (fill_reg < FW'(DEPTH));
    assign div_sum  = div_reg + 4'd1;
    assign bits_sum = bits_reg + 4'd1;
    assign fill_dec = (fill_reg != '0) ? fill_reg - 1'b1 : fill_reg;

    // next state
    always_comb
    begin
        wp_next    = wp_reg;
        fp_next    = fp_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        line_next  = line_reg;
        if (push_ok)
        begin
            wp_next   = ptr_inc(wp_reg);
            fill_next = fill_reg + 1'b1;
        end
        if (fire && op.tick && cfg.enable)
        begin
            div_next = div_sum;
            if (div_sum >= cfg.period)
            begin
                div_next = 4'd0;
                case (phase_reg)
                    PH_IDLE:
                    begin
                        line_next = 1'b1;
                        if (fill_reg != '0)
                        begin
                            shift_next = head_reg;
                            bits_next  = 4'd0;
                            phase_next = PH_START;
                            fp_next    = ptr_inc(fp_reg);
                        end
                    end
                    PH_START:
                    begin
                        line_next  = 1'b0;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        line_next  = shift_reg[0];
                        shift_next = {1'b0, shift_reg[7:1]};
                        bits_next  = bits_sum;
                        if (bits_sum >= BITS_PER_WORD)
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    default:
                    begin
                        line_next = 1'b1;
                        fill_next = fill_dec;
                        if (fill_dec != '0)
                        begin
                            shift_next = head_reg;
                            bits_next  = 4'd0;
                            phase_next = PH_START;
                            fp_next    = ptr_inc(fp_reg);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // status after this word
    always_comb
    begin
        stat.line     = line_next;
        stat.accepted = push_ok;
        stat.space    = (fill_next < FW'(DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            fp_reg    <= '0;
            fill_reg  <= '0;
            phase_reg <= PH_IDLE;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            div_reg   <= 4'd0;
            line_reg  <= 1'b1;
        end
        else
        begin
            wp_reg    <= wp_next;
            fp_reg    <= fp_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            div_reg   <= div_next;
            line_reg  <= line_next;
        end
    end

    // hold the entry at the fetch pointer, bypassing a same-cycle write
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wp_reg] <= op.tx_byte;
        end
        if (push_ok && (wp_reg == fp_next))
        begin
            head_reg <= op.tx_byte;
        end
        else
        begin
            head_reg <= mem[fp_next];
        end
    end

endmodule

[src/ouf_rx.sv]
// Receive side: start-edge detect, bit sampler and byte FIFO with prefetched head.
// Depends on ouf_pkg.
module ouf_rx
    import ouf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  op_t      op,
    input  cfg_t     cfg,
    output rx_stat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    head_reg;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [FW-1:0] fill_reg, fill_next;
    phase_t        phase_reg, phase_next;
    logic [3:0]    bits_reg, bits_next;
    logic [7:0]    shift_reg, shift_next;
    logic [3:0]    wait_reg, wait_next;
    logic          prev_reg, prev_next;
    logic          pop_ok;
    logic          store;
    logic [3:0]    wait_sum;
    logic [3:0]    bits_sum;
    logic [7:0]    shift_set;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign pop_ok    = fire && op.pop && (fill_reg != '0);
    assign wait_sum  = wait_reg + 4'd1;
    assign bits_sum  = bits_reg + 4'd1;
    assign shift_set = shift_reg | (8'(op.rx_line) << bits_reg[2:0]);

    // next state
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        wait_next  = wait_reg;
        prev_next  = prev_reg;
        store      = 1'b0;
        if (pop_ok)
        begin
            rp_next   = ptr_inc(rp_reg);
            fill_next = fill_reg - 1'b1;
        end
        if (fire && op.tick && cfg.enable)
        begin
            prev_next = op.rx_line;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (prev_reg && !op.rx_line)
                    begin
                        phase_next = PH_START;
                        wait_next  = 4'd0;
                    end
                end
                PH_START:
                begin
                    phase_next = PH_DATA;
                    wait_next  = 4'd0;
                    bits_next  = 4'd0;
                    shift_next = 8'd0;
                end
                PH_DATA:
                begin
                    wait_next = wait_sum;
                    if (wait_sum >= cfg.period)
                    begin
                        shift_next = shift_set;
                        bits_next  = bits_sum;
                        if (bits_sum >= BITS_PER_WORD)
                        begin
                            phase_next = PH_IDLE;
                            if (fill_reg < FW'(DEPTH))
                            begin
                                store     = 1'b1;
                                wp_next   = ptr_inc(wp_reg);
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            wait_next = 4'd0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // status after this word
    always_comb
    begin
        stat.valid    = pop_ok;
        stat.data     = pop_ok ? head_reg : 8'd0;
        stat.nonempty = (fill_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            fill_reg  <= '0;
            phase_reg <= PH_IDLE;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            wait_reg  <= 4'd0;
            prev_reg  <= 1'b1;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            wait_reg  <= wait_next;
            prev_reg  <= prev_next;
        end
    end

    // hold the entry at the read pointer, bypassing a same-cycle write
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem[wp_reg] <= shift_set;
        end
        if (store && (wp_reg == rp_next))
        begin
            head_reg <= shift_set;
        end
        else
        begin
            head_reg <= mem[rp_next];
        end
    end

endmodule
